// ===== sv/dprt_pkg.sv =====
// ----------------------------------------------------------------------------
// Pixel remap table package
// Shared widths, codes, state machine type and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dprt_pkg;

   localparam int COORD_BITS    = 10;
   localparam int DIM_BITS      = COORD_BITS + 1;
   localparam int PT_BITS       = COORD_BITS + 2;
   localparam int POS_BITS      = COORD_BITS + 4;
   localparam int IDX_BITS      = 2 * DIM_BITS + 1;
   localparam int WORD_BITS     = 32;
   localparam int OP_BITS       = 2;
   localparam int ORIENT_BITS   = 3;
   localparam int MODE_BITS     = 2;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = DIM_BITS;

   localparam int SOURCE_ENTRIES_DEF     = 16384;
   localparam int CORRECTION_ENTRIES_DEF = 16384;

   localparam logic [WORD_BITS-1:0] ONE_WORD = 32'h3F80_0000;
   localparam logic [2*PT_BITS-1:0] RESET_POINT = '1;

   // Item operation codes.
   localparam logic [OP_BITS-1:0] OP_LOOKUP     = 2'd0;
   localparam logic [OP_BITS-1:0] OP_WRITE_ONE  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_WRITE_RECT = 2'd2;

   // Correction modes; any mode with the high bit set is bypass.
   localparam logic [MODE_BITS-1:0] MODE_SOURCE = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_TARGET = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_BYPASS = 2'd2;

   // Orientation codes.
   localparam logic [ORIENT_BITS-1:0] OR_UP        = 3'd0;
   localparam logic [ORIENT_BITS-1:0] OR_DOWN      = 3'd1;
   localparam logic [ORIENT_BITS-1:0] OR_LEFT      = 3'd2;
   localparam logic [ORIENT_BITS-1:0] OR_RIGHT     = 3'd3;
   localparam logic [ORIENT_BITS-1:0] OR_UP_REV    = 3'd4;
   localparam logic [ORIENT_BITS-1:0] OR_DOWN_REV  = 3'd5;
   localparam logic [ORIENT_BITS-1:0] OR_LEFT_REV  = 3'd6;
   localparam logic [ORIENT_BITS-1:0] OR_RIGHT_REV = 3'd7;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] REG_SOURCE_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SOURCE_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_TARGET_LEFT     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_TARGET_TOP      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_TARGET_WIDTH    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_TARGET_HEIGHT   = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_ORIENTATION     = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_CORRECTION_MODE = 3'd7;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SIDX,
      ST_SCHK,
      ST_LAST,
      ST_RCHK,
      ST_RECT,
      ST_PREAD,
      ST_ORIENT,
      ST_OCHK,
      ST_TIDX,
      ST_TCHK,
      ST_CREAD,
      ST_CDATA,
      ST_WRITE,
      ST_RCW,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      MUL_SOURCE,
      MUL_LAST,
      MUL_TARGET
   } mul_sel_type;

   typedef struct packed {
      logic        latch;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        sidx_load;
      logic        rect_step;
      logic        pt_read;
      logic        orient_load;
      logic        map_load;
      logic        bypass_set;
      logic        cidx_load;
      logic        corr_read;
      logic        corr_capture;
      logic        write_one;
      logic        corr_write;
      logic        ok_set;
      logic        clear_step;
   } cmd_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               bypass;
      logic               mode_target;
      logic               src_ok;
      logic               in_tgt;
      logic               rect_ok;
      logic               rect_last;
      logic               prod_corr_ok;
      logic               clear_done;
   } status_type;

endpackage

// ===== sv/dprt_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Carries lookup and write items into the remap table.
// ----------------------------------------------------------------------------
interface dprt_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [dprt_pkg::OP_BITS-1:0]           op;
   logic [dprt_pkg::COORD_BITS-1:0]        source_x;
   logic [dprt_pkg::COORD_BITS-1:0]        source_y;
   logic [dprt_pkg::COORD_BITS-1:0]        source_x_last;
   logic [dprt_pkg::COORD_BITS-1:0]        source_y_last;
   logic [dprt_pkg::DIM_BITS-1:0]          target_x;
   logic [dprt_pkg::DIM_BITS-1:0]          target_y;
   logic [dprt_pkg::WORD_BITS-1:0]         correction_word;

   modport source (output valid, op, source_x, source_y, source_x_last, source_y_last,
                   target_x, target_y, correction_word, input ready);
   modport sink (input valid, op, source_x, source_y, source_x_last, source_y_last,
                 target_x, target_y, correction_word, output ready);
endinterface

// ===== sv/dprt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Carries one result item for every request item.
// ----------------------------------------------------------------------------
interface dprt_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  ok;
   logic signed [dprt_pkg::PT_BITS-1:0]   mapped_x;
   logic signed [dprt_pkg::PT_BITS-1:0]   mapped_y;
   logic [dprt_pkg::WORD_BITS-1:0]        correction_out;

   modport source (output valid, ok, mapped_x, mapped_y, correction_out, input ready);
   modport sink (input valid, ok, mapped_x, mapped_y, correction_out, output ready);
endinterface

// ===== sv/dprt_csr_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data.
// ----------------------------------------------------------------------------
interface dprt_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [dprt_pkg::CSR_IDX_BITS-1:0]     index;
   logic [dprt_pkg::CSR_DATA_BITS-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/dprt_dp.sv =====
// ----------------------------------------------------------------------------
// Pixel remap table datapath
// Configuration registers, item registers, the shared index multiplier,
// orientation logic, both stores and the result registers.
// ----------------------------------------------------------------------------
module dprt_dp #(
   parameter int SOURCE_ENTRIES     = dprt_pkg::SOURCE_ENTRIES_DEF,
   parameter int CORRECTION_ENTRIES = dprt_pkg::CORRECTION_ENTRIES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [dprt_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [dprt_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  logic [dprt_pkg::OP_BITS-1:0]         req_op,
   input  logic [dprt_pkg::COORD_BITS-1:0]      req_source_x,
   input  logic [dprt_pkg::COORD_BITS-1:0]      req_source_y,
   input  logic [dprt_pkg::COORD_BITS-1:0]      req_source_x_last,
   input  logic [dprt_pkg::COORD_BITS-1:0]      req_source_y_last,
   input  logic [dprt_pkg::DIM_BITS-1:0]        req_target_x,
   input  logic [dprt_pkg::DIM_BITS-1:0]        req_target_y,
   input  logic [dprt_pkg::WORD_BITS-1:0]       req_correction_word,
   input  dprt_pkg::cmd_type                    cmd,
   output dprt_pkg::status_type                 status,
   output logic                                 rsp_ok,
   output logic signed [dprt_pkg::PT_BITS-1:0]  rsp_mapped_x,
   output logic signed [dprt_pkg::PT_BITS-1:0]  rsp_mapped_y,
   output logic [dprt_pkg::WORD_BITS-1:0]       rsp_correction_out
);

   localparam int CB = dprt_pkg::COORD_BITS;
   localparam int DB = dprt_pkg::DIM_BITS;
   localparam int PB = dprt_pkg::PT_BITS;
   localparam int QB = dprt_pkg::POS_BITS;
   localparam int IB = dprt_pkg::IDX_BITS;
   localparam int WB = dprt_pkg::WORD_BITS;
   localparam int SRC_AW = $clog2(SOURCE_ENTRIES);
   localparam int COR_AW = $clog2(CORRECTION_ENTRIES);
   localparam int MAX_ENTRIES = (SOURCE_ENTRIES > CORRECTION_ENTRIES) ?
                                SOURCE_ENTRIES : CORRECTION_ENTRIES;
   localparam int CLR_BITS = $clog2(MAX_ENTRIES) + 1;

   // Configuration registers.
   logic [DB-1:0]                         src_w_ff, src_h_ff, tgt_w_ff, tgt_h_ff;
   logic [CB-1:0]                         tgt_l_ff, tgt_t_ff;
   logic [dprt_pkg::ORIENT_BITS-1:0]      orient_ff;
   logic [dprt_pkg::MODE_BITS-1:0]        mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff  <= DB'(128);
         src_h_ff  <= DB'(128);
         tgt_l_ff  <= '0;
         tgt_t_ff  <= '0;
         tgt_w_ff  <= '0;
         tgt_h_ff  <= '0;
         orient_ff <= dprt_pkg::OR_UP;
         mode_ff   <= dprt_pkg::MODE_BYPASS;
      end else if (csr_valid) begin
         unique case (csr_index)
            dprt_pkg::REG_SOURCE_WIDTH:    src_w_ff  <= csr_data;
            dprt_pkg::REG_SOURCE_HEIGHT:   src_h_ff  <= csr_data;
            dprt_pkg::REG_TARGET_LEFT:     tgt_l_ff  <= csr_data[CB-1:0];
            dprt_pkg::REG_TARGET_TOP:      tgt_t_ff  <= csr_data[CB-1:0];
            dprt_pkg::REG_TARGET_WIDTH:    tgt_w_ff  <= csr_data;
            dprt_pkg::REG_TARGET_HEIGHT:   tgt_h_ff  <= csr_data;
            dprt_pkg::REG_ORIENTATION:     orient_ff <= csr_data[dprt_pkg::ORIENT_BITS-1:0];
            dprt_pkg::REG_CORRECTION_MODE: mode_ff   <= csr_data[dprt_pkg::MODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Item registers.
   logic [dprt_pkg::OP_BITS-1:0] op_ff;
   logic [CB-1:0]                sx_ff, sy_ff, sxl_ff, syl_ff, cur_x_ff, cur_y_ff;
   logic [DB-1:0]                tx_ff, ty_ff;
   logic [WB-1:0]                word_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_op;
         sx_ff   <= req_source_x;
         sy_ff   <= req_source_y;
         sxl_ff  <= req_source_x_last;
         syl_ff  <= req_source_y_last;
         tx_ff   <= req_target_x;
         ty_ff   <= req_target_y;
         word_ff <= req_correction_word;
      end
   end

   // Geometry of the target rectangle.
   logic              rect_valid;
   logic signed [QB-1:0] left_s, top_s, right_s, bottom_s;

   assign rect_valid = (tgt_w_ff != '0) && (tgt_h_ff != '0);
   assign left_s     = signed'(QB'(tgt_l_ff));
   assign top_s      = signed'(QB'(tgt_t_ff));
   assign right_s    = left_s + signed'(QB'(tgt_w_ff)) - QB'(1);
   assign bottom_s   = top_s + signed'(QB'(tgt_h_ff)) - QB'(1);

   // Point under test: the target point of a write, or the oriented lookup point.
   logic signed [QB-1:0] dx_ff, dy_ff;
   logic [2*PB-1:0]      pt_rd_ff;
   logic signed [QB-1:0] px, py, ox, oy;

   always_comb begin
      if (mode_ff[1]) begin
         px = signed'(QB'(sx_ff));
         py = signed'(QB'(sy_ff));
      end else begin
         px = QB'(signed'(pt_rd_ff[PB-1:0]));
         py = QB'(signed'(pt_rd_ff[2*PB-1:PB]));
      end
      ox = px;
      oy = py;
      if (rect_valid) begin
         case (orient_ff)
            dprt_pkg::OR_DOWN:      begin ox = right_s - px;  oy = bottom_s - py; end
            dprt_pkg::OR_LEFT:      begin ox = py;            oy = px;            end
            dprt_pkg::OR_RIGHT:     begin ox = bottom_s - py; oy = right_s - px;  end
            dprt_pkg::OR_UP_REV:    begin ox = right_s - px;  oy = py;            end
            dprt_pkg::OR_DOWN_REV:  begin ox = px;            oy = bottom_s - py; end
            dprt_pkg::OR_LEFT_REV:  begin ox = bottom_s - py; oy = px;            end
            dprt_pkg::OR_RIGHT_REV: begin ox = py;            oy = right_s - px;  end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         dx_ff <= signed'(QB'(req_target_x));
         dy_ff <= signed'(QB'(req_target_y));
      end else if (cmd.orient_load) begin
         dx_ff <= ox;
         dy_ff <= oy;
      end
   end

   logic in_tgt;
   assign in_tgt = rect_valid && (dx_ff >= left_s) && (dx_ff <= right_s) &&
                   (dy_ff >= top_s) && (dy_ff <= bottom_s);

   // Shared index multiplier: a * b + c, registered.
   logic [DB-1:0]         ma, mb, mc;
   logic signed [QB-1:0]  rel_x, rel_y;
   logic [IB-1:0]         prod_ff;

   assign rel_x = dx_ff - left_s;
   assign rel_y = dy_ff - top_s;

   always_comb begin
      case (cmd.mul_sel)
         dprt_pkg::MUL_LAST: begin
            ma = DB'(syl_ff);
            mb = src_w_ff;
            mc = DB'(sxl_ff);
         end
         dprt_pkg::MUL_TARGET: begin
            ma = rel_y[DB-1:0];
            mb = tgt_w_ff;
            mc = rel_x[DB-1:0];
         end
         default: begin
            ma = DB'(sy_ff);
            mb = src_w_ff;
            mc = DB'(sx_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= IB'(ma) * IB'(mb) + IB'(mc);
      end
   end

   // Source and correction indexes, and the rectangle walk.
   logic [IB-1:0] sidx_ff, cidx_ff;
   logic [IB-1:0] caddr;

   assign caddr = (mode_ff == dprt_pkg::MODE_TARGET) ? cidx_ff : sidx_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cur_x_ff <= req_source_x;
         cur_y_ff <= req_source_y;
      end else if (cmd.rect_step) begin
         if (cur_x_ff == sxl_ff) begin
            cur_x_ff <= sx_ff;
            cur_y_ff <= cur_y_ff + CB'(1);
         end else begin
            cur_x_ff <= cur_x_ff + CB'(1);
         end
      end
      if (cmd.sidx_load) begin
         sidx_ff <= prod_ff;
      end else if (cmd.rect_step) begin
         if (cur_x_ff == sxl_ff) begin
            sidx_ff <= sidx_ff + IB'(src_w_ff) - IB'(sxl_ff - sx_ff);
         end else begin
            sidx_ff <= sidx_ff + IB'(1);
         end
      end
      if (cmd.cidx_load) begin
         cidx_ff <= prod_ff;
      end
   end

   // Clearing pass counter.
   logic [CLR_BITS-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + CLR_BITS'(1);
      end
   end

   // Stores.
   logic [2*PB-1:0] pt_mem [SOURCE_ENTRIES];
   logic [WB-1:0]   cor_mem [CORRECTION_ENTRIES];
   logic [WB-1:0]   cor_rd_ff;
   logic [2*PB-1:0] pt_pack;

   assign pt_pack = {PB'(ty_ff), PB'(tx_ff)};

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         if (clr_ff < CLR_BITS'(SOURCE_ENTRIES)) begin
            pt_mem[clr_ff[SRC_AW-1:0]] <= dprt_pkg::RESET_POINT;
         end
      end else if (cmd.write_one || cmd.rect_step) begin
         pt_mem[sidx_ff[SRC_AW-1:0]] <= pt_pack;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         if (clr_ff < CLR_BITS'(CORRECTION_ENTRIES)) begin
            cor_mem[clr_ff[COR_AW-1:0]] <= dprt_pkg::ONE_WORD;
         end
      end else if (cmd.write_one || cmd.corr_write ||
                   (cmd.rect_step && mode_ff == dprt_pkg::MODE_SOURCE)) begin
         cor_mem[caddr[COR_AW-1:0]] <= word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pt_read) begin
         pt_rd_ff <= pt_mem[sidx_ff[SRC_AW-1:0]];
      end
      if (cmd.corr_read) begin
         cor_rd_ff <= cor_mem[caddr[COR_AW-1:0]];
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         rsp_ok             <= 1'b0;
         rsp_mapped_x       <= '0;
         rsp_mapped_y       <= '0;
         rsp_correction_out <= '0;
      end else begin
         if (cmd.map_load) begin
            rsp_mapped_x <= dx_ff[PB-1:0];
            rsp_mapped_y <= dy_ff[PB-1:0];
         end
         if (cmd.bypass_set) begin
            rsp_ok             <= 1'b1;
            rsp_correction_out <= dprt_pkg::ONE_WORD;
         end
         if (cmd.corr_capture) begin
            rsp_ok             <= 1'b1;
            rsp_correction_out <= cor_rd_ff;
         end
         if (cmd.ok_set) begin
            rsp_ok <= 1'b1;
         end
      end
   end

   // Status towards the controller.
   logic src_fit, last_fit;

   assign src_fit  = prod_ff < IB'(SOURCE_ENTRIES);
   assign last_fit = src_fit &&
                     ((mode_ff == dprt_pkg::MODE_TARGET) ||
                      (prod_ff < IB'(CORRECTION_ENTRIES)));

   always_comb begin
      status.op           = op_ff;
      status.bypass       = mode_ff[1];
      status.mode_target  = (mode_ff == dprt_pkg::MODE_TARGET);
      status.src_ok       = (DB'(sx_ff) < src_w_ff) && (DB'(sy_ff) < src_h_ff) && src_fit;
      status.in_tgt       = in_tgt;
      status.rect_ok      = (sxl_ff >= sx_ff) && (syl_ff >= sy_ff) &&
                            (DB'(sxl_ff) < src_w_ff) && (DB'(syl_ff) < src_h_ff) &&
                            in_tgt && last_fit;
      status.rect_last    = (cur_x_ff == sxl_ff) && (cur_y_ff == syl_ff);
      status.prod_corr_ok = prod_ff < IB'(CORRECTION_ENTRIES);
      status.clear_done   = (clr_ff == CLR_BITS'(MAX_ENTRIES));
   end

endmodule

// ===== sv/dprt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Pixel remap table controller
// Sequences the clearing pass, lookups, single writes and rectangle walks.
// ----------------------------------------------------------------------------
module dprt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  dprt_pkg::status_type  status,
   output dprt_pkg::cmd_type     cmd
);

   dprt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dprt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dprt_pkg::ST_CLEAR: begin
            if (status.clear_done) state_in = dprt_pkg::ST_IDLE;
         end
         dprt_pkg::ST_IDLE: begin
            if (req_valid) state_in = dprt_pkg::ST_SIDX;
         end
         dprt_pkg::ST_SIDX: begin
            // The item is latched; dispatch on it here.
            if (status.op == dprt_pkg::OP_LOOKUP && status.bypass) begin
               state_in = dprt_pkg::ST_ORIENT;
            end else if (status.bypass) begin
               state_in = dprt_pkg::ST_RESP;
            end else if (status.op == dprt_pkg::OP_WRITE_RECT) begin
               state_in = dprt_pkg::ST_LAST;
            end else if (status.op == dprt_pkg::OP_LOOKUP ||
                         status.op == dprt_pkg::OP_WRITE_ONE) begin
               state_in = dprt_pkg::ST_SCHK;
            end else begin
               state_in = dprt_pkg::ST_RESP;
            end
         end
         dprt_pkg::ST_SCHK: begin
            if (!status.src_ok) begin
               state_in = dprt_pkg::ST_RESP;
            end else if (status.op == dprt_pkg::OP_LOOKUP) begin
               state_in = dprt_pkg::ST_PREAD;
            end else if (!status.in_tgt) begin
               state_in = dprt_pkg::ST_RESP;
            end else if (status.mode_target) begin
               state_in = dprt_pkg::ST_TIDX;
            end else if (status.prod_corr_ok) begin
               state_in = dprt_pkg::ST_WRITE;
            end else begin
               state_in = dprt_pkg::ST_RESP;
            end
         end
         dprt_pkg::ST_LAST: state_in = dprt_pkg::ST_RCHK;
         dprt_pkg::ST_RCHK: begin
            state_in = status.rect_ok ? dprt_pkg::ST_RECT : dprt_pkg::ST_RESP;
         end
         dprt_pkg::ST_RECT: begin
            if (status.rect_last) begin
               state_in = status.mode_target ? dprt_pkg::ST_TIDX : dprt_pkg::ST_RESP;
            end
         end
         dprt_pkg::ST_PREAD:  state_in = dprt_pkg::ST_ORIENT;
         dprt_pkg::ST_ORIENT: state_in = dprt_pkg::ST_OCHK;
         dprt_pkg::ST_OCHK: begin
            if (status.bypass || !status.in_tgt) begin
               state_in = dprt_pkg::ST_RESP;
            end else if (status.mode_target) begin
               state_in = dprt_pkg::ST_TIDX;
            end else if (status.prod_corr_ok) begin
               state_in = dprt_pkg::ST_CREAD;
            end else begin
               state_in = dprt_pkg::ST_RESP;
            end
         end
         dprt_pkg::ST_TIDX: state_in = dprt_pkg::ST_TCHK;
         dprt_pkg::ST_TCHK: begin
            if (!status.prod_corr_ok) begin
               state_in = dprt_pkg::ST_RESP;
            end else if (status.op == dprt_pkg::OP_LOOKUP) begin
               state_in = dprt_pkg::ST_CREAD;
            end else if (status.op == dprt_pkg::OP_WRITE_ONE) begin
               state_in = dprt_pkg::ST_WRITE;
            end else begin
               state_in = dprt_pkg::ST_RCW;
            end
         end
         dprt_pkg::ST_CREAD: state_in = dprt_pkg::ST_CDATA;
         dprt_pkg::ST_CDATA: state_in = dprt_pkg::ST_RESP;
         dprt_pkg::ST_WRITE: state_in = dprt_pkg::ST_RESP;
         dprt_pkg::ST_RCW:   state_in = dprt_pkg::ST_RESP;
         dprt_pkg::ST_RESP: begin
            if (rsp_ready) state_in = dprt_pkg::ST_IDLE;
         end
         default: state_in = dprt_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      cmd.mul_sel = dprt_pkg::MUL_SOURCE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         dprt_pkg::ST_CLEAR: cmd.clear_step = !status.clear_done;
         dprt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         dprt_pkg::ST_SIDX: cmd.mul_en = 1'b1;
         dprt_pkg::ST_SCHK: cmd.sidx_load = 1'b1;
         dprt_pkg::ST_LAST: begin
            cmd.sidx_load = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = dprt_pkg::MUL_LAST;
         end
         dprt_pkg::ST_RCHK: ;
         dprt_pkg::ST_RECT: begin
            cmd.rect_step = 1'b1;
            cmd.ok_set    = status.rect_last && !status.mode_target;
         end
         dprt_pkg::ST_PREAD:  cmd.pt_read = 1'b1;
         dprt_pkg::ST_ORIENT: cmd.orient_load = 1'b1;
         dprt_pkg::ST_OCHK: begin
            cmd.map_load   = 1'b1;
            cmd.bypass_set = status.bypass;
         end
         dprt_pkg::ST_TIDX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = dprt_pkg::MUL_TARGET;
         end
         dprt_pkg::ST_TCHK:  cmd.cidx_load = 1'b1;
         dprt_pkg::ST_CREAD: cmd.corr_read = 1'b1;
         dprt_pkg::ST_CDATA: cmd.corr_capture = 1'b1;
         dprt_pkg::ST_WRITE: begin
            cmd.write_one = 1'b1;
            cmd.ok_set    = 1'b1;
         end
         dprt_pkg::ST_RCW: begin
            cmd.corr_write = 1'b1;
            cmd.ok_set     = 1'b1;
         end
         dprt_pkg::ST_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

// ===== sv/detector_pixel_remap_table.sv =====
// ----------------------------------------------------------------------------
// Detector pixel remap table
// Maps detector source pixels to oriented target points with a correction
// word, and stores those mappings for single pixels or source rectangles.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Payload
//   req_if    in         valid/ready    op, source and target points, word
//   rsp_if    out        valid/ready    ok, mapped_x, mapped_y, correction_out
//   csr_if    in         valid/ready    register index, write data
//
// One item is in work at a time. A lookup in bypass orients the source point
// directly; otherwise it reads the source store, orients the point and reads
// the correction store, after a target index step in per-target mode. A single
// write or a rectangle write stores its entries, with a target index step in
// per-target mode. An item that is refused ends sooner; a write in bypass is
// refused without touching the stores. The index multiplier is shared.
// After reset a clearing pass over max(SOURCE_ENTRIES, CORRECTION_ENTRIES)
// entries fills both stores before the first item is taken.
// The result is held until the response side takes it; a stalled response
// holds off the next request. Configuration writes are always taken.
//
module detector_pixel_remap_table #(
   parameter int SOURCE_ENTRIES     = dprt_pkg::SOURCE_ENTRIES_DEF,
   parameter int CORRECTION_ENTRIES = dprt_pkg::CORRECTION_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   dprt_req_if.sink    req_if,
   dprt_rsp_if.source  rsp_if,
   dprt_csr_if.sink    csr_if
);

   dprt_pkg::cmd_type    cmd;
   dprt_pkg::status_type status;

   // Register writes land in the datapath's configuration registers directly;
   // the port never stalls.
   assign csr_if.ready = 1'b1;

   // The controller owns both handshakes and steps the datapath through the
   // index, read, orientation and write phases of each item.
   dprt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the stores, the geometry and the result registers
   // that drive the response payload.
   dprt_dp #(
      .SOURCE_ENTRIES     (SOURCE_ENTRIES),
      .CORRECTION_ENTRIES (CORRECTION_ENTRIES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_if.valid),
      .csr_index           (csr_if.index),
      .csr_data            (csr_if.data),
      .req_op              (req_if.op),
      .req_source_x        (req_if.source_x),
      .req_source_y        (req_if.source_y),
      .req_source_x_last   (req_if.source_x_last),
      .req_source_y_last   (req_if.source_y_last),
      .req_target_x        (req_if.target_x),
      .req_target_y        (req_if.target_y),
      .req_correction_word (req_if.correction_word),
      .cmd                 (cmd),
      .status              (status),
      .rsp_ok              (rsp_if.ok),
      .rsp_mapped_x        (rsp_if.mapped_x),
      .rsp_mapped_y        (rsp_if.mapped_y),
      .rsp_correction_out  (rsp_if.correction_out)
   );

endmodule
